@@ design/kst_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Shared types, constants and the micro-step program of the speed tracker.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int IO_W           = 32;
    localparam int NOISE_W        = 31;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;
    localparam int STEP_W         = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_COVARIANCE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPEED      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE       = 3'd4;

    localparam logic [NOISE_W-1:0] RST_PROCESS_NOISE      = 31'd1678;
    localparam logic [NOISE_W-1:0] RST_MEASUREMENT_NOISE  = 31'd167772;
    localparam logic [NOISE_W-1:0] RST_INITIAL_COVARIANCE = 31'd1677722;
    localparam logic [IO_W-1:0]    RST_INITIAL_SPEED      = 32'd33554432;
    localparam logic [IO_W-1:0]    RST_INITIAL_RATE       = 32'd0;

    typedef enum logic [2:0] {K_LD, K_ADD, K_SUB, K_ST, K_SKIP, K_MUL, K_DIV} t_kind;

    typedef enum logic [3:0] {
        R_IN, R_Z, R_X0, R_X1, R_P00, R_P01, R_P11, R_Q, R_R, R_S, R_Y,
        R_K0, R_K1, R_M, R_OUT
    } t_reg;

    typedef struct packed {
        t_kind kind;
        t_reg  a;
        t_reg  b;
    } t_uop;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT} t_state;
    typedef enum logic [1:0] {U_IDLE, U_MUL, U_DIV, U_FIN} t_unit;

    typedef struct packed {
        logic accept;
        logic issue;
        t_uop uop;
    } t_cmd;

    typedef struct packed {
        logic unit_done;
        logic s_pos;
    } t_sts;

    localparam logic [STEP_W-1:0] OUT_STEP = 6'd46;

    function automatic t_uop f_uop(input logic [STEP_W-1:0] step);
        t_uop u;
        case (step)
            6'd0:    u = '{K_LD,   R_IN,  R_IN};
            6'd1:    u = '{K_ST,   R_Z,   R_Z};
            6'd2:    u = '{K_LD,   R_X0,  R_X0};
            6'd3:    u = '{K_ADD,  R_X1,  R_X1};
            6'd4:    u = '{K_ST,   R_X0,  R_X0};
            6'd5:    u = '{K_LD,   R_P00, R_P00};
            6'd6:    u = '{K_ADD,  R_P01, R_P01};
            6'd7:    u = '{K_ADD,  R_P01, R_P01};
            6'd8:    u = '{K_ADD,  R_P11, R_P11};
            6'd9:    u = '{K_ADD,  R_Q,   R_Q};
            6'd10:   u = '{K_ST,   R_P00, R_P00};
            6'd11:   u = '{K_LD,   R_P01, R_P01};
            6'd12:   u = '{K_ADD,  R_P11, R_P11};
            6'd13:   u = '{K_ST,   R_P01, R_P01};
            6'd14:   u = '{K_LD,   R_P11, R_P11};
            6'd15:   u = '{K_ADD,  R_Q,   R_Q};
            6'd16:   u = '{K_ST,   R_P11, R_P11};
            6'd17:   u = '{K_LD,   R_P00, R_P00};
            6'd18:   u = '{K_ADD,  R_R,   R_R};
            6'd19:   u = '{K_ST,   R_S,   R_S};
            6'd20:   u = '{K_SKIP, R_S,   R_S};
            6'd21:   u = '{K_DIV,  R_P00, R_K0};
            6'd22:   u = '{K_DIV,  R_P01, R_K1};
            6'd23:   u = '{K_LD,   R_Z,   R_Z};
            6'd24:   u = '{K_SUB,  R_X0,  R_X0};
            6'd25:   u = '{K_ST,   R_Y,   R_Y};
            6'd26:   u = '{K_MUL,  R_K0,  R_Y};
            6'd27:   u = '{K_LD,   R_X0,  R_X0};
            6'd28:   u = '{K_ADD,  R_M,   R_M};
            6'd29:   u = '{K_ST,   R_X0,  R_X0};
            6'd30:   u = '{K_MUL,  R_K1,  R_Y};
            6'd31:   u = '{K_LD,   R_X1,  R_X1};
            6'd32:   u = '{K_ADD,  R_M,   R_M};
            6'd33:   u = '{K_ST,   R_X1,  R_X1};
            6'd34:   u = '{K_MUL,  R_K1,  R_P01};
            6'd35:   u = '{K_LD,   R_P11, R_P11};
            6'd36:   u = '{K_SUB,  R_M,   R_M};
            6'd37:   u = '{K_ST,   R_P11, R_P11};
            6'd38:   u = '{K_MUL,  R_K0,  R_P01};
            6'd39:   u = '{K_LD,   R_P01, R_P01};
            6'd40:   u = '{K_SUB,  R_M,   R_M};
            6'd41:   u = '{K_ST,   R_P01, R_P01};
            6'd42:   u = '{K_MUL,  R_K0,  R_P00};
            6'd43:   u = '{K_LD,   R_P00, R_P00};
            6'd44:   u = '{K_SUB,  R_M,   R_M};
            6'd45:   u = '{K_ST,   R_P00, R_P00};
            6'd46:   u = '{K_LD,   R_X0,  R_X0};
            default: u = '{K_ST,   R_OUT, R_OUT};
        endcase
        return u;
    endfunction

endpackage

@@ design/kst_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_ctrl
// Sequencer that steps the datapath through one filter update per sample.
// ----------------------------------------------------------------------------
module kst_ctrl
    import kst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state             r_state, n_state;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    t_uop               uop;
    logic               out_free;

    assign uop      = f_uop(r_step);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_RUN;
                    n_step  = '0;
                end
            end
            ST_RUN: begin
                case (uop.kind)
                    K_SKIP: begin
                        n_step = i_sts.s_pos ? r_step + 6'd1 : OUT_STEP;
                    end
                    K_MUL, K_DIV: begin
                        n_state = ST_WAIT;
                    end
                    K_ST: begin
                        if (uop.a == R_OUT) begin
                            if (out_free) begin
                                n_out_valid = 1'b1;
                                n_state     = ST_IDLE;
                            end
                        end else begin
                            n_step = r_step + 6'd1;
                        end
                    end
                    default: begin
                        n_step = r_step + 6'd1;
                    end
                endcase
            end
            ST_WAIT: begin
                if (i_sts.unit_done) begin
                    n_state = ST_RUN;
                    n_step  = r_step + 6'd1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready      = (r_state == ST_IDLE);
        o_valid      = r_out_valid;
        o_cmd.accept = (r_state == ST_IDLE) && i_valid;
        o_cmd.uop    = uop;
        o_cmd.issue  = (r_state == ST_RUN) && (uop.kind != K_SKIP)
                       && !((uop.kind == K_ST) && (uop.a == R_OUT) && !out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ design/kst_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_dp
// Registers, saturating accumulator and bit-serial multiply/divide unit.
// ----------------------------------------------------------------------------
module kst_dp
    import kst_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic signed [IO_W-1:0] i_measured_speed,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output logic signed [IO_W-1:0] o_estimated_speed,
    output logic                  o_saturated
);

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int AW = ((W > IO_W) ? W : IO_W) + 3;
    localparam int MW = 2 * W;
    localparam int CW = $clog2(W + F);

    localparam logic signed [AW-1:0] VMAX_A = AW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [AW-1:0] VMIN_A = -VMAX_A - AW'(1);
    localparam logic signed [AW-1:0] OMAX_A = AW'(64'sd2147483647);
    localparam logic signed [AW-1:0] OMIN_A = AW'(-64'sd2147483648);
    localparam logic signed [W-1:0]  VMAX_W = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0]  VMIN_W = {1'b1, {(W - 1){1'b0}}};
    localparam logic [MW:0]          LIM_POS = {{(MW - W + 2){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [MW:0]          LIM_NEG = LIM_POS + (MW + 1)'(1);
    localparam logic [MW:0]          HALF = {{MW{1'b0}}, 1'b1} << (F - 1);

    function automatic logic signed [W-1:0] sat_w(input logic signed [AW-1:0] v);
        if (v > VMAX_A) begin
            return VMAX_W;
        end else if (v < VMIN_A) begin
            return VMIN_W;
        end
        return v[W-1:0];
    endfunction

    function automatic logic [W-1:0] abs_w(input logic signed [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [NOISE_W-1:0]   r_q_raw, r_r_raw, r_pinit_raw;
    logic [IO_W-1:0]      r_x0_init, r_x1_init;
    logic                 r_reload;

    logic signed [W-1:0]  r_x0, r_x1, r_p00, r_p01, r_p11;
    logic signed [W-1:0]  r_z, r_s, r_y, r_k0, r_k1, r_m;
    logic signed [IO_W-1:0] r_in;
    logic signed [AW-1:0] r_acc;
    logic                 r_flag;
    logic signed [IO_W-1:0] r_out_speed;
    logic                 r_out_sat;

    t_unit                r_unit, n_unit;
    logic [CW-1:0]        r_cnt;
    logic                 r_neg, r_over;
    logic [MW-1:0]        r_mcand, r_prod;
    logic [W-1:0]         r_mplier, r_rem, r_quo;
    logic [W+F-1:0]       r_dvd;
    t_reg                 r_udst;

    logic signed [W-1:0]  q_w, r_w, pinit_w, x0_init_w, x1_init_w;
    logic signed [W-1:0]  a_w, b_w;
    logic signed [AW-1:0] acc_src;
    logic signed [W-1:0]  st_val;
    logic                 st_over;
    logic signed [IO_W-1:0] out_val;
    logic                 out_over;
    logic [W:0]           div_t;
    logic                 div_ge;
    logic [MW:0]          fin_rnd, fin_mag;
    logic                 fin_clip;
    logic signed [W-1:0]  fin_res;

    assign q_w       = sat_w(AW'(signed'({1'b0, r_q_raw})));
    assign r_w       = sat_w(AW'(signed'({1'b0, r_r_raw})));
    assign pinit_w   = sat_w(AW'(signed'({1'b0, r_pinit_raw})));
    assign x0_init_w = sat_w(AW'(signed'(r_x0_init)));
    assign x1_init_w = sat_w(AW'(signed'(r_x1_init)));

    always_comb begin
        case (i_cmd.uop.a)
            R_Z:     a_w = r_z;
            R_X0:    a_w = r_x0;
            R_X1:    a_w = r_x1;
            R_P00:   a_w = r_p00;
            R_P01:   a_w = r_p01;
            R_P11:   a_w = r_p11;
            R_Q:     a_w = q_w;
            R_R:     a_w = r_w;
            R_S:     a_w = r_s;
            R_Y:     a_w = r_y;
            R_K0:    a_w = r_k0;
            R_K1:    a_w = r_k1;
            R_M:     a_w = r_m;
            default: a_w = '0;
        endcase
        case (i_cmd.uop.b)
            R_Y:     b_w = r_y;
            R_P00:   b_w = r_p00;
            R_P01:   b_w = r_p01;
            default: b_w = '0;
        endcase
        acc_src = (i_cmd.uop.a == R_IN) ? AW'(r_in) : AW'(a_w);
    end

    always_comb begin
        st_val   = sat_w(r_acc);
        st_over  = (r_acc > VMAX_A) || (r_acc < VMIN_A);
        out_over = (r_acc > OMAX_A) || (r_acc < OMIN_A);
        if (r_acc > OMAX_A) begin
            out_val = 32'sh7FFFFFFF;
        end else if (r_acc < OMIN_A) begin
            out_val = 32'sh80000000;
        end else begin
            out_val = r_acc[IO_W-1:0];
        end
    end

    always_comb begin
        div_t    = {r_rem, r_dvd[W+F-1]};
        div_ge   = div_t >= {1'b0, r_s};
        fin_rnd  = {1'b0, r_prod} + HALF;
        fin_mag  = (r_unit == U_FIN && r_udst == R_M) ? (fin_rnd >> F) : (MW + 1)'(r_quo);
        fin_clip = r_over || (fin_mag > (r_neg ? LIM_NEG : LIM_POS));
        if (fin_clip) begin
            fin_res = r_neg ? VMIN_W : VMAX_W;
        end else begin
            fin_res = r_neg ? -fin_mag[W-1:0] : fin_mag[W-1:0];
        end
    end

    always_comb begin
        n_unit = r_unit;
        case (r_unit)
            U_IDLE: begin
                if (i_cmd.issue && i_cmd.uop.kind == K_MUL) begin
                    n_unit = U_MUL;
                end else if (i_cmd.issue && i_cmd.uop.kind == K_DIV) begin
                    n_unit = U_DIV;
                end
            end
            U_MUL, U_DIV: begin
                if (r_cnt == '0) begin
                    n_unit = U_FIN;
                end
            end
            default: begin
                n_unit = U_IDLE;
            end
        endcase
    end

    assign o_sts.unit_done   = (r_unit == U_FIN);
    assign o_sts.s_pos       = !r_s[W-1] && (r_s != '0);
    assign o_estimated_speed = r_out_speed;
    assign o_saturated       = r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit <= U_IDLE;
        end else begin
            r_unit <= n_unit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_raw     <= RST_PROCESS_NOISE;
            r_r_raw     <= RST_MEASUREMENT_NOISE;
            r_pinit_raw <= RST_INITIAL_COVARIANCE;
            r_x0_init   <= RST_INITIAL_SPEED;
            r_x1_init   <= RST_INITIAL_RATE;
            r_reload    <= 1'b1;
            r_flag      <= 1'b0;
        end else begin
            r_reload <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE: begin
                        r_q_raw  <= i_cfg_data[NOISE_W-1:0];
                        r_reload <= 1'b1;
                    end
                    CFG_MEASUREMENT_NOISE: begin
                        r_r_raw  <= i_cfg_data[NOISE_W-1:0];
                        r_reload <= 1'b1;
                    end
                    CFG_INITIAL_COVARIANCE: begin
                        r_pinit_raw <= i_cfg_data[NOISE_W-1:0];
                        r_reload    <= 1'b1;
                    end
                    CFG_INITIAL_SPEED: begin
                        r_x0_init <= i_cfg_data;
                        r_reload  <= 1'b1;
                    end
                    CFG_INITIAL_RATE: begin
                        r_x1_init <= i_cfg_data;
                        r_reload  <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.accept) begin
                r_flag <= 1'b0;
            end else if (i_cmd.issue && i_cmd.uop.kind == K_ST) begin
                r_flag <= r_flag | st_over;
            end else if (r_unit == U_FIN) begin
                r_flag <= r_flag | fin_clip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_reload) begin
            r_x0  <= x0_init_w;
            r_x1  <= x1_init_w;
            r_p00 <= pinit_w;
            r_p01 <= '0;
            r_p11 <= pinit_w;
        end
        if (i_cmd.accept) begin
            r_in <= i_measured_speed;
        end
        if (i_cmd.issue) begin
            case (i_cmd.uop.kind)
                K_LD:  r_acc <= acc_src;
                K_ADD: r_acc <= r_acc + acc_src;
                K_SUB: r_acc <= r_acc - acc_src;
                K_ST: begin
                    case (i_cmd.uop.a)
                        R_Z:   r_z   <= st_val;
                        R_X0:  r_x0  <= st_val;
                        R_X1:  r_x1  <= st_val;
                        R_P00: r_p00 <= st_val;
                        R_P01: r_p01 <= st_val;
                        R_P11: r_p11 <= st_val;
                        R_S:   r_s   <= st_val;
                        R_Y:   r_y   <= st_val;
                        R_OUT: begin
                            r_out_speed <= out_val;
                            r_out_sat   <= r_flag | out_over;
                        end
                        default: begin
                        end
                    endcase
                end
                K_MUL: begin
                    r_cnt    <= CW'(W - 1);
                    r_neg    <= a_w[W-1] ^ b_w[W-1];
                    r_over   <= 1'b0;
                    r_mcand  <= MW'(abs_w(a_w));
                    r_mplier <= abs_w(b_w);
                    r_prod   <= '0;
                    r_udst   <= R_M;
                end
                K_DIV: begin
                    r_cnt  <= CW'(W + F - 1);
                    r_neg  <= a_w[W-1];
                    r_over <= 1'b0;
                    r_dvd  <= {abs_w(a_w), {F{1'b0}}};
                    r_rem  <= '0;
                    r_quo  <= '0;
                    r_udst <= i_cmd.uop.b;
                end
                default: begin
                end
            endcase
        end
        case (r_unit)
            U_MUL: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - CW'(1);
            end
            U_DIV: begin
                r_rem <= div_ge ? W'(div_t - {1'b0, r_s}) : div_t[W-1:0];
                r_quo <= {r_quo[W-2:0], div_ge};
                if (div_ge && r_cnt >= CW'(W)) begin
                    r_over <= 1'b1;
                end
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CW'(1);
            end
            U_FIN: begin
                case (r_udst)
                    R_K0:    r_k0 <= fin_res;
                    R_K1:    r_k1 <= fin_res;
                    default: r_m  <= fin_res;
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

@@ design/kalman_speed_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_speed_tracker_top
// Two-state constant-velocity Kalman filter on a scalar speed measurement.
//
//   channel   signals                                   direction
//   input     i_valid / o_ready, i_measured_speed        in
//   result    o_valid / i_ready, o_estimated_speed,      out
//             o_saturated
//   config    i_cfg_valid / o_cfg_ready, i_cfg_index,    in
//             i_cfg_data
//
// The time from transaction to result is set by the single bit-serial
// multiply/divide unit that all five products and both gain quotients share;
// the correction, and with it the unit, is skipped when S is not positive. A new
// sample is taken only after the result of the last one has been stored.
// Reset and each config write to indexes 0 to 4 reload state and covariance.
// A stalled result holds; the final step waits for the output register to free.
// ----------------------------------------------------------------------------
module kalman_speed_tracker_top
    import kst_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic signed [IO_W-1:0] i_measured_speed,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic signed [IO_W-1:0] o_estimated_speed,
    output logic                   o_saturated
);

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    kst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    kst_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_measured_speed  (i_measured_speed),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_estimated_speed (o_estimated_speed),
        .o_saturated       (o_saturated)
    );

endmodule

@@ design/kst_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_checker
// Port-level checks of the speed tracker, bound to the top level.
// ----------------------------------------------------------------------------
module kst_checker
    import kst_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_valid,
    input logic                   o_ready,
    input logic                   o_valid,
    input logic                   i_ready,
    input logic signed [IO_W-1:0] o_estimated_speed,
    input logic                   o_saturated
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_estimated_speed)
                                && $stable(o_saturated))
        else $error("result changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input ready right after a transaction");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !$rose(o_valid))
        else $error("result appeared one cycle after a transaction");

    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> o_ready)
        else $error("new result without input ready");

endmodule

bind kalman_speed_tracker_top kst_checker u_kst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (i_valid),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_estimated_speed (o_estimated_speed),
    .o_saturated       (o_saturated)
);
